FILE: sv/mlsp_pkg.sv
// Package with the constants and shared types of the multi-layer shelf packer.
package mlsp_pkg;

    localparam int ATLAS_WIDTH  = 2048;
    localparam int ATLAS_HEIGHT = 2048;
    localparam int LAYER_COUNT  = 8;
    localparam int FIRST_LAYER  = 0;

    localparam int COORD_W = 12;
    localparam int YPEN_W  = 13;
    localparam int LAYER_W = 3;
    localparam int SUM_W   = 14;
    localparam int LAYER_DEPTH = 8;

    localparam logic [SUM_W-1:0] ATLAS_W_LIM = SUM_W'(ATLAS_WIDTH);
    localparam logic [SUM_W-1:0] ATLAS_H_LIM = SUM_W'(ATLAS_HEIGHT);
    localparam logic [SUM_W-1:0] Y_PEN_SAT   = SUM_W'(ATLAS_HEIGHT + 1);
    localparam logic [LAYER_W-1:0] FIRST_IDX = LAYER_W'(FIRST_LAYER);
    localparam logic [LAYER_W-1:0] LAST_IDX  = LAYER_W'(LAYER_COUNT - 1);
    localparam bit RANGE_EMPTY = (FIRST_LAYER >= LAYER_COUNT);

    typedef struct packed {
        logic [COORD_W-1:0] x_pen;
        logic [YPEN_W-1:0]  y_pen;
        logic [COORD_W-1:0] tallest;
    } shelf_t;

    typedef struct packed {
        logic               fits;
        shelf_t             shelf;
        logic [COORD_W-1:0] x_at;
        logic [COORD_W-1:0] y_at;
    } try_result_t;

endpackage

FILE: sv/mlsp_layer_unit.sv
// Shared unit that tries to place one rectangle into the shelf of one layer.
module mlsp_layer_unit
    import mlsp_pkg::*;
(
    input  shelf_t             shelf_in,
    input  logic [COORD_W-1:0] rect_w,
    input  logic [COORD_W-1:0] rect_h,
    output try_result_t        result
);

    logic [SUM_W-1:0]   x_sum;
    logic               overflow;
    logic [SUM_W-1:0]   ny;
    logic [SUM_W-1:0]   ny_sat;
    logic [YPEN_W-1:0]  y_eff;
    logic [COORD_W-1:0] x_eff;
    logic [COORD_W-1:0] t_eff;
    logic [SUM_W-1:0]   y_sum;
    logic [SUM_W-1:0]   x_adv;

    always_comb begin
        x_sum    = SUM_W'(shelf_in.x_pen) + SUM_W'(rect_w);
        overflow = x_sum > ATLAS_W_LIM;
        ny       = SUM_W'(shelf_in.y_pen) + SUM_W'(shelf_in.tallest) + SUM_W'(1);
        ny_sat   = (ny > Y_PEN_SAT) ? Y_PEN_SAT : ny;
        y_eff    = overflow ? ny_sat[YPEN_W-1:0] : shelf_in.y_pen;
        x_eff    = overflow ? '0 : shelf_in.x_pen;
        t_eff    = overflow ? '0 : shelf_in.tallest;
        y_sum    = SUM_W'(y_eff) + SUM_W'(rect_h);
        x_adv    = SUM_W'(x_eff) + SUM_W'(rect_w) + SUM_W'(1);

        result.fits          = y_sum <= ATLAS_H_LIM;
        result.x_at          = x_eff;
        result.y_at          = y_eff[COORD_W-1:0];
        result.shelf.y_pen   = y_eff;
        result.shelf.x_pen   = x_eff;
        result.shelf.tallest = t_eff;
        if (result.fits) begin
            result.shelf.x_pen   = x_adv[COORD_W-1:0];
            result.shelf.tallest = (rect_h > t_eff) ? rect_h : t_eff;
        end
    end

endmodule

FILE: sv/multi_layer_shelf_packer.sv
// Top level of the multi-layer shelf packer: sequencer and per-layer shelf state.
//
// A request on the s_ channel carries a rectangle's width and height. The block
// tries the layers in order, one layer per clock cycle through a shared try unit,
// and returns one result on the m_ channel: a placed flag, the layer and the
// x,y offset, with zeros when no layer takes the rectangle.
// s_ready is high only while the block is idle. After a request is accepted the
// block tries the layers in turn, from 1 up to the layer count (8) of them, and
// then presents the result; a rectangle wider than the atlas is answered without
// trying a layer. The result then waits in the output register, with m_valid
// high, until m_ready is seen; a stalled receiver holds the block, and the next
// request can be taken in the cycle after the result is delivered. The block thus
// takes no new request before the last result has been delivered.
// A synchronous active-low reset on aresetn empties every layer (all pens and
// shelf heights at zero) and drops any result in flight.
module multi_layer_shelf_packer
    import mlsp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COORD_W-1:0] s_rect_width,
    input  logic [COORD_W-1:0] s_rect_height,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_placed,
    output logic [LAYER_W-1:0] m_layer_index,
    output logic [COORD_W-1:0] m_x_offset,
    output logic [COORD_W-1:0] m_y_offset
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [LAYER_W-1:0] layer_reg, layer_next;
    logic [COORD_W-1:0] w_reg, w_next;
    logic [COORD_W-1:0] h_reg, h_next;
    shelf_t             shelf_reg [LAYER_DEPTH];
    shelf_t             shelf_next [LAYER_DEPTH];
    logic               placed_reg, placed_next;
    logic [LAYER_W-1:0] out_layer_reg, out_layer_next;
    logic [COORD_W-1:0] out_x_reg, out_x_next;
    logic [COORD_W-1:0] out_y_reg, out_y_next;
    try_result_t        try_res;

    mlsp_layer_unit u_layer_unit (
        .shelf_in (shelf_reg[layer_reg]),
        .rect_w   (w_reg),
        .rect_h   (h_reg),
        .result   (try_res)
    );

    always_comb begin
        state_next     = state_reg;
        layer_next     = layer_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        shelf_next     = shelf_reg;
        placed_next    = placed_reg;
        out_layer_next = out_layer_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    w_next         = s_rect_width;
                    h_next         = s_rect_height;
                    layer_next     = FIRST_IDX;
                    placed_next    = 1'b0;
                    out_layer_next = '0;
                    out_x_next     = '0;
                    out_y_next     = '0;
                    if (RANGE_EMPTY || ({2'b00, s_rect_width} > ATLAS_W_LIM)) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                shelf_next[layer_reg] = try_res.shelf;
                if (try_res.fits) begin
                    placed_next    = 1'b1;
                    out_layer_next = layer_reg;
                    out_x_next     = try_res.x_at;
                    out_y_next     = try_res.y_at;
                    state_next     = ST_DONE;
                end else if (layer_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                end else begin
                    layer_next = layer_reg + LAYER_W'(1);
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            layer_reg <= '0;
            for (int i = 0; i < LAYER_DEPTH; i++) begin
                shelf_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            layer_reg <= layer_next;
            shelf_reg <= shelf_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg         <= w_next;
        h_reg         <= h_next;
        placed_reg    <= placed_next;
        out_layer_reg <= out_layer_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_DONE);
    assign m_placed      = placed_reg;
    assign m_layer_index = out_layer_reg;
    assign m_x_offset    = out_x_reg;
    assign m_y_offset    = out_y_reg;

endmodule

FILE: tb/tb_multi_layer_shelf_packer.sv
// Self-checking testbench for the multi-layer shelf packer: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps

module tb_multi_layer_shelf_packer;
    import mlsp_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 8;
    localparam int PHASE_COUNT  = 4;
    localparam int PHASE_ITEMS  = 312;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 4 * LAYER_COUNT;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 50;
    localparam int CASE_COUNT   = 18;

    typedef struct packed {
        logic               placed;
        logic [LAYER_W-1:0] layer;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } placement_t;

    typedef struct packed {
        bit         given;
        placement_t answer;
    } rect_answer_t;

    typedef struct packed {
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        bit                 given;
        placement_t         answer;
    } rect_case_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [COORD_W-1:0] s_rect_width;
    logic [COORD_W-1:0] s_rect_height;
    logic               m_valid;
    logic               m_ready;
    logic               m_placed;
    logic [LAYER_W-1:0] m_layer_index;
    logic [COORD_W-1:0] m_x_offset;
    logic [COORD_W-1:0] m_y_offset;

    logic [COORD_W-1:0] shelf_x   [LAYER_DEPTH];
    logic [YPEN_W-1:0]  shelf_y   [LAYER_DEPTH];
    logic [COORD_W-1:0] shelf_top [LAYER_DEPTH];

    placement_t   placement_q[$];
    rect_answer_t typed_answer_q[$];

    int mismatch_count  = 0;
    int cycle_count     = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_left       = 0;
    bit hold_request    = 1'b0;
    bit hold_taken      = 1'b0;

    int phase_sender_pct [PHASE_COUNT] = '{0, 70, 0, 35};
    int phase_stall_pct  [PHASE_COUNT] = '{0, 0, 70, 35};

    // Rows with an answer given are oversized requests, which no state can place,
    // and the very first request after reset.
    rect_case_t directed_cases [CASE_COUNT] = '{
        '{12'd0,    12'd0,    1'b1, '{1'b1, 3'd0, 12'd0, 12'd0}},
        '{12'd2049, 12'd5,    1'b1, '0},
        '{12'd4095, 12'd4095, 1'b1, '0},
        '{12'd5,    12'd2049, 1'b1, '0},
        '{12'hAAA,  12'h555,  1'b1, '0},
        '{12'd2048, 12'd0,    1'b0, '0},
        '{12'd2048, 12'd2048, 1'b0, '0},
        '{12'd2048, 12'd2048, 1'b0, '0},
        '{12'h555,  12'hAAA,  1'b1, '0},
        '{12'd0,    12'd2048, 1'b0, '0},
        '{12'd2047, 12'd1,    1'b0, '0},
        '{12'd1,    12'd1,    1'b0, '0},
        '{12'd4095, 12'd0,    1'b1, '0},
        '{12'd2048, 12'd4095, 1'b1, '0},
        '{12'd1024, 12'd1024, 1'b0, '0},
        '{12'd1023, 12'd1023, 1'b0, '0},
        '{12'd0,    12'd0,    1'b0, '0},
        '{12'd2048, 12'd1,    1'b0, '0}
    };

    multi_layer_shelf_packer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rect_width  (s_rect_width),
        .s_rect_height (s_rect_height),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_placed      (m_placed),
        .m_layer_index (m_layer_index),
        .m_x_offset    (m_x_offset),
        .m_y_offset    (m_y_offset)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic placement_t place_rect(input logic [COORD_W-1:0] w,
                                              input logic [COORD_W-1:0] h);
        placement_t res;
        int px, py, top;
        res = '0;
        if (int'(w) > ATLAS_WIDTH) return res;
        for (int k = FIRST_LAYER; k < LAYER_COUNT && k < LAYER_DEPTH; k++) begin
            px  = int'(shelf_x[k]);
            py  = int'(shelf_y[k]);
            top = int'(shelf_top[k]);
            if (px + int'(w) > ATLAS_WIDTH) begin
                py  = (py + top + 1 > ATLAS_HEIGHT + 1) ? ATLAS_HEIGHT + 1 : py + top + 1;
                px  = 0;
                top = 0;
            end
            if (py + int'(h) <= ATLAS_HEIGHT) begin
                res.placed = 1'b1;
                res.layer  = LAYER_W'(k);
                res.x      = COORD_W'(px);
                res.y      = COORD_W'(py);
                px = px + int'(w) + 1;
                if (int'(h) > top) top = int'(h);
            end
            shelf_x[k]   = COORD_W'(px);
            shelf_y[k]   = YPEN_W'(py);
            shelf_top[k] = COORD_W'(top);
            if (res.placed) return res;
        end
        return res;
    endfunction

    function automatic void pick_rect(output logic [COORD_W-1:0] w,
                                      output logic [COORD_W-1:0] h);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70) begin
            w = COORD_W'($urandom_range(63));
            h = COORD_W'($urandom_range(63));
        end else if (roll < 85) begin
            w = COORD_W'($urandom_range(767, 64));
            h = COORD_W'($urandom_range(767, 64));
        end else if (roll < 90) begin
            w = COORD_W'($urandom_range(ATLAS_WIDTH, 768));
            h = COORD_W'($urandom_range(ATLAS_HEIGHT, 768));
        end else if (roll < 95) begin
            w = COORD_W'($urandom_range(ATLAS_WIDTH));
            h = COORD_W'($urandom_range(ATLAS_HEIGHT));
        end else begin
            w = COORD_W'($urandom_range(4095));
            h = COORD_W'($urandom_range(4095));
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic offer_rect(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                              input rect_answer_t note);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        typed_answer_q = {typed_answer_q, note};
        s_valid       <= 1'b1;
        s_rect_width  <= w;
        s_rect_height <= h;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        placement_t   want;
        rect_answer_t note;
        if (!aresetn) begin
            for (int k = 0; k < LAYER_DEPTH; k++) begin
                shelf_x[k]   = '0;
                shelf_y[k]   = '0;
                shelf_top[k] = '0;
            end
            placement_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                want = place_rect(s_rect_width, s_rect_height);
                note = typed_answer_q.pop_front();
                if (note.given) want = note.answer;
                placement_q = {placement_q, want};
            end
            if (m_valid && m_ready) begin
                if (placement_q.size() == 0) begin
                    report_mismatch("result with no request pending, placed",
                                    int'(m_placed), 0);
                end else begin
                    want = placement_q.pop_front();
                    if (m_placed !== want.placed)
                        report_mismatch("placed", int'(m_placed), int'(want.placed));
                    if (m_layer_index !== want.layer)
                        report_mismatch("layer_index", int'(m_layer_index),
                                        int'(want.layer));
                    if (m_x_offset !== want.x)
                        report_mismatch("x_offset", int'(m_x_offset), int'(want.x));
                    if (m_y_offset !== want.y)
                        report_mismatch("y_offset", int'(m_y_offset), int'(want.y));
                end
            end
        end
    end

    initial begin
        rect_answer_t       note;
        logic [COORD_W-1:0] w, h;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_rect_width  = '0;
        s_rect_height = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < CASE_COUNT; i++) begin
            note.given  = directed_cases[i].given;
            note.answer = directed_cases[i].answer;
            offer_rect(directed_cases[i].w, directed_cases[i].h, note);
        end

        // The first phase opens with a long receiver hold so the block backs up.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            sender_idle_pct = phase_sender_pct[p];
            recv_stall_pct  = phase_stall_pct[p];
            if (p == 0) hold_request = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pick_rect(w, h);
                note = '0;
                offer_rect(w, h, note);
            end
        end
        s_valid <= 1'b0;

        while (placement_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
